// File: rtl/core/barometric_sensor_compensation_macros.svh
// ============================================================================
// Barometric sensor compensation assertion macros
// Property wrappers for the compensation block; empty bodies in synthesis.
// ============================================================================
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent in the same cycle implies the consequent.
`define BPC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies the consequent in the next cycle.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPC_ASSERT_IMPLIES(label, ante, cons, msg)
`define BPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/core/bpc_pkg.sv
// ============================================================================
// Barometric sensor compensation package
// Register indexes, compensation constants and shared types.
// ============================================================================
package bpc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [2:0] CFG_B1_B2   = 3'd3;
    localparam logic [2:0] CFG_MC_MD   = 3'd4;
    localparam logic [2:0] CFG_OSS     = 3'd5;

    localparam logic [1:0] OSS_RESET = 2'd3;

    // Compensation constants as 32-bit words.
    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] B4_BIAS   = 32'd32768;
    localparam logic [31:0] B7_SCALE  = 32'd50000;
    localparam logic [31:0] P_COEF1   = 32'd3038;
    localparam logic [31:0] P_COEF2   = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] P_COEF3   = 32'd3791;

    // Divider sizing.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic start;
        logic sgn;
    } bpc_div_req_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// File: rtl/core/bpc_div.sv
// ============================================================================
// Iterative 32-bit divider
// Restoring division, one quotient bit per cycle, signed or unsigned.
// ============================================================================
module bpc_div
    import bpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bpc_div_req_t req,
    input  logic [31:0]  dividend,
    input  logic [31:0]  divisor,
    output logic         done,
    output logic [31:0]  quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          quo_reg;
    logic [31:0]          dvs_reg;
    logic                 neg_reg;
    logic [31:0]          q_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_next;
    logic [31:0] quo_next;
    logic [31:0] a_mag;
    logic [31:0] b_mag;

    assign shifted  = {rem_reg, quo_reg[31]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign rem_next = ge ? diff[31:0] : shifted[31:0];
    assign quo_next = {quo_reg[30:0], ge};
    assign a_mag    = (req.sgn && dividend[31]) ? (32'd0 - dividend) : dividend;
    assign b_mag    = (req.sgn && divisor[31])  ? (32'd0 - divisor)  : divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= a_mag;
            dvs_reg <= b_mag;
            neg_reg <= req.sgn & (dividend[31] ^ divisor[31]);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                q_reg <= neg_reg ? (32'd0 - quo_next) : quo_next;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/core/barometric_sensor_compensation.sv
// ============================================================================
// Barometric sensor compensation
// Integer temperature and pressure compensation from factory calibration.
// ============================================================================
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  config   | cfg_write            | cfg_index, cfg_data
//  input    | in_valid / in_stall  | kind, raw_reading
//  output   | out_valid / out_stall| result_kind, temperature_tenths,
//           |                      | pressure_pa, divide_error
//
//  A temperature item keeps in_stall high through T0, T1, TD and FIN, and a
//  pressure item through P0..P12 and FIN, so a new item waits until the last
//  is done; a zero divisor skips the division and cuts the busy time. The
//  32-step shared divider sets most of that; one shared multiplier serializes
//  the rest. A stalled output register holds FIN, so a waiting result blocks
//  the next input. Reset clears the calibration words and B5, oversampling 3.
//
module barometric_sensor_compensation
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [18:0] raw_reading,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] temperature_tenths,
    output logic [19:0] pressure_pa,
    output logic        divide_error
);

`include "barometric_sensor_compensation_macros.svh"

    // Sequencer states. Temperature runs T0..TD, pressure runs P0..P12,
    // and both finish in FIN, which waits for a free output register.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T0   = 5'd1;
    localparam logic [4:0] S_T1   = 5'd2;
    localparam logic [4:0] S_TD   = 5'd3;
    localparam logic [4:0] S_P0   = 5'd4;
    localparam logic [4:0] S_P1   = 5'd5;
    localparam logic [4:0] S_P2   = 5'd6;
    localparam logic [4:0] S_P3   = 5'd7;
    localparam logic [4:0] S_P4   = 5'd8;
    localparam logic [4:0] S_P5   = 5'd9;
    localparam logic [4:0] S_P6   = 5'd10;
    localparam logic [4:0] S_P7   = 5'd11;
    localparam logic [4:0] S_P8   = 5'd12;
    localparam logic [4:0] S_PD   = 5'd13;
    localparam logic [4:0] S_P9   = 5'd14;
    localparam logic [4:0] S_P10  = 5'd15;
    localparam logic [4:0] S_P11  = 5'd16;
    localparam logic [4:0] S_P12  = 5'd17;
    localparam logic [4:0] S_FIN  = 5'd18;

    // Calibration registers and the kept B5 term.
    logic [31:0] ac12_reg;
    logic [31:0] ac34_reg;
    logic [31:0] ac56_reg;
    logic [31:0] b12_reg;
    logic [31:0] mcmd_reg;
    logic [1:0]  oss_reg;
    logic [31:0] tt_reg;

    logic [4:0]  state_reg;
    logic [4:0]  state_next;

    // Item and working registers.
    logic        kind_reg;
    logic [18:0] raw_reg;
    logic [31:0] m_reg;
    logic [31:0] acc_reg;
    logic [31:0] b6sq_reg;
    logic [31:0] b3_reg;
    logic [31:0] b4_reg;
    logic [31:0] p_reg;
    logic        big_reg;

    // Pending result, held until the output register is free.
    logic [15:0] r_temp_reg;
    logic [19:0] r_pres_reg;
    logic        r_err_reg;

    logic        out_valid_reg;
    logic        res_kind_reg;
    logic [15:0] res_temp_reg;
    logic [19:0] res_pres_reg;
    logic        res_err_reg;

    // Decoded calibration words, all sign or zero extended to 32 bits.
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sext16(ac12_reg[31:16]);
    assign ac2 = sext16(ac12_reg[15:0]);
    assign ac3 = sext16(ac34_reg[31:16]);
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = sext16(b12_reg[31:16]);
    assign b2  = sext16(b12_reg[15:0]);
    assign mc  = sext16(mcmd_reg[31:16]);
    assign md  = sext16(mcmd_reg[15:0]);

    logic [31:0] raw32;
    logic [31:0] b6;
    assign raw32 = {13'd0, raw_reg};
    assign b6    = tt_reg - B6_OFFSET;

    // Shifted views of the last product.
    logic [31:0] m_asr11, m_asr12, m_asr13, m_asr15, m_asr16;
    assign m_asr11 = 32'($signed(m_reg) >>> 11);
    assign m_asr12 = 32'($signed(m_reg) >>> 12);
    assign m_asr13 = 32'($signed(m_reg) >>> 13);
    assign m_asr15 = 32'($signed(m_reg) >>> 15);
    assign m_asr16 = 32'($signed(m_reg) >>> 16);

    // Temperature divisor and B3, B4 helper terms.
    logic [31:0] t_den;
    logic [31:0] x3_sum;
    logic [31:0] b3_pre;
    logic [31:0] b3_val;
    logic [31:0] x3_b4;
    assign t_den  = m_asr15 + md;
    assign x3_sum = acc_reg + m_asr11;
    assign b3_pre = ((ac1 << 2) + x3_sum) << oss_reg;
    assign b3_val = 32'($signed(b3_pre + 32'd2) >>> 2);
    assign x3_b4  = 32'($signed(acc_reg + m_asr16 + 32'd2) >>> 2);

    // Shared multiplier; the low 32 bits of the product are kept.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_lo;
    assign mul_lo = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T0:
            begin
                mul_a = raw32 - ac6;
                mul_b = ac5;
            end
            S_P0:
            begin
                mul_a = b6;
                mul_b = b6;
            end
            S_P1:
            begin
                mul_a = b2;
                mul_b = m_asr12;
            end
            S_P2:
            begin
                mul_a = ac2;
                mul_b = b6;
            end
            S_P3:
            begin
                mul_a = ac3;
                mul_b = b6;
            end
            S_P4:
            begin
                mul_a = b1;
                mul_b = b6sq_reg;
            end
            S_P6:
            begin
                mul_a = ac4;
                mul_b = acc_reg;
            end
            S_P7:
            begin
                mul_a = raw32 - b3_reg;
                mul_b = B7_SCALE >> oss_reg;
            end
            S_P9:
            begin
                mul_a = 32'($signed(p_reg) >>> 8);
                mul_b = 32'($signed(p_reg) >>> 8);
            end
            S_P10:
            begin
                mul_a = m_reg;
                mul_b = P_COEF1;
            end
            S_P11:
            begin
                mul_a = p_reg;
                mul_b = P_COEF2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider request: signed for the temperature path, unsigned for B7 / B4.
    bpc_div_req_t div_req;
    logic [31:0]  div_a;
    logic [31:0]  div_b;
    logic         div_done;
    logic [31:0]  div_q;
    logic         t_start;
    logic         p_start;

    assign t_start = (state_reg == S_T1) && (t_den != 32'd0);
    assign p_start = (state_reg == S_P8) && (b4_reg != 32'd0);

    always_comb
    begin
        div_req.start = t_start | p_start;
        div_req.sgn   = t_start;
        if (t_start)
        begin
            div_a = mc << 11;
            div_b = t_den;
        end
        else
        begin
            div_a = m_reg[31] ? m_reg : (m_reg << 1);
            div_b = b4_reg;
        end
    end

    bpc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Final temperature and pressure words before saturation.
    logic [31:0] b5_val;
    logic [31:0] t_word;
    logic [15:0] t_sat;
    logic [31:0] p_word;
    logic [19:0] p_sat;
    logic [31:0] p_quo;

    assign b5_val = acc_reg + div_q;
    assign t_word = 32'($signed(b5_val + 32'd8) >>> 4);
    assign p_quo  = big_reg ? (div_q << 1) : div_q;
    assign p_word = p_reg + 32'($signed(acc_reg + m_asr16 + P_COEF3) >>> 4);

    always_comb
    begin
        if ($signed(t_word) < -32'sd32768)
        begin
            t_sat = 16'h8000;
        end
        else if ($signed(t_word) > 32'sd32767)
        begin
            t_sat = 16'h7FFF;
        end
        else
        begin
            t_sat = t_word[15:0];
        end

        if (p_word[31])
        begin
            p_sat = '0;
        end
        else if (p_word[30:20] != 11'd0)
        begin
            p_sat = 20'hFFFFF;
        end
        else
        begin
            p_sat = p_word[19:0];
        end
    end

    logic in_xfer;
    logic out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = kind ? S_P0 : S_T0;
            S_T0:   state_next = S_T1;
            S_T1:   state_next = (t_den == 32'd0) ? S_FIN : S_TD;
            S_TD:   if (div_done) state_next = S_FIN;
            S_P0:   state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = S_P5;
            S_P5:   state_next = S_P6;
            S_P6:   state_next = S_P7;
            S_P7:   state_next = S_P8;
            S_P8:   state_next = (b4_reg == 32'd0) ? S_FIN : S_PD;
            S_PD:   if (div_done) state_next = S_P9;
            S_P9:   state_next = S_P10;
            S_P10:  state_next = S_P11;
            S_P11:  state_next = S_P12;
            S_P12:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ac12_reg  <= '0;
            ac34_reg  <= '0;
            ac56_reg  <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= OSS_RESET;
            tt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_AC1_AC2: ac12_reg <= cfg_data;
                    CFG_AC3_AC4: ac34_reg <= cfg_data;
                    CFG_AC5_AC6: ac56_reg <= cfg_data;
                    CFG_B1_B2:   b12_reg  <= cfg_data;
                    CFG_MC_MD:   mcmd_reg <= cfg_data;
                    CFG_OSS:     oss_reg  <= cfg_data[1:0];
                    default:     ;
                endcase
            end
            // B5 is kept only when the temperature division completes.
            if (state_reg == S_TD && div_done)
            begin
                tt_reg <= b5_val;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        m_reg <= mul_lo;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_reg   <= kind;
                    raw_reg    <= raw_reading;
                    r_temp_reg <= '0;
                    r_pres_reg <= '0;
                    r_err_reg  <= 1'b0;
                end
            end
            S_T1:
            begin
                acc_reg <= m_asr15;
                if (t_den == 32'd0)
                begin
                    r_err_reg <= 1'b1;
                end
            end
            S_TD:
            begin
                if (div_done)
                begin
                    r_temp_reg <= t_sat;
                end
            end
            S_P1: b6sq_reg <= m_asr12;
            S_P2: acc_reg  <= m_asr11;
            S_P3: b3_reg   <= b3_val;
            S_P4: acc_reg  <= m_asr13;
            S_P5: acc_reg  <= x3_b4 + B4_BIAS;
            S_P7: b4_reg   <= m_reg >> 15;
            S_P8:
            begin
                big_reg <= m_reg[31];
                if (b4_reg == 32'd0)
                begin
                    r_err_reg <= 1'b1;
                end
            end
            S_PD:
            begin
                if (div_done)
                begin
                    p_reg <= p_quo;
                end
            end
            S_P11: acc_reg    <= m_asr16;
            S_P12: r_pres_reg <= p_sat;
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            res_kind_reg <= kind_reg;
            res_temp_reg <= r_temp_reg;
            res_pres_reg <= r_pres_reg;
            res_err_reg  <= r_err_reg;
        end
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = out_valid_reg;
    assign result_kind        = res_kind_reg;
    assign temperature_tenths = res_temp_reg;
    assign pressure_pa        = res_pres_reg;
    assign divide_error       = res_err_reg;

    // A transfer on the input always starts a computation.
    `BPC_ASSERT_NEXT(a_accept_busy, in_xfer, state_reg != S_IDLE, "item accepted but sequencer idle")
    // The divider only finishes while a division step is waiting on it.
    `BPC_ASSERT_IMPLIES(a_div_done_wait, div_done, state_reg == S_TD || state_reg == S_PD, "stray divider completion")
    // A failed division reports zero in both result fields.
    `BPC_ASSERT_IMPLIES(a_err_zero, out_valid && divide_error, temperature_tenths == 16'd0 && pressure_pa == 20'd0, "error result not zeroed")
    // A temperature result never carries a pressure value.
    `BPC_ASSERT_IMPLIES(a_temp_no_pres, out_valid && !result_kind, pressure_pa == 20'd0, "pressure set on temperature result")

endmodule
